>>> hw/rtl/dss_pkg.sv
package dss_pkg;

    // Fixed field widths of the block's ports
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SEP_LEN_W  = 4;
    localparam int unsigned SEP_BYTES_W = 64;
    localparam int unsigned LIMIT_W    = 31;
    localparam int unsigned OUT_OFF_W  = 32;
    localparam int unsigned CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEP_LEN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEP_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPLIT_LIMIT = 2'd2;

    // The top split limit stands for no limit at all
    localparam logic [LIMIT_W-1:0] LIMIT_UNBOUNDED = 31'h7FFF_FFFF;

    // Result queue geometry
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = 2;
    localparam int unsigned FIFO_CNT_W = 3;

    // One result beat
    typedef struct packed {
        logic [OUT_OFF_W-1:0] start;
        logic [OUT_OFF_W-1:0] length;
        logic                 last;
    } piece_t;

    // Up to two results produced by one input byte, in order
    typedef struct packed {
        logic   valid0;
        logic   valid1;
        piece_t piece0;
        piece_t piece1;
    } push_t;

    // Space, tab, newline, vertical tab, form feed and carriage return
    function automatic logic is_space(input logic [BYTE_W-1:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

endpackage

>>> hw/rtl/delimiter_stream_splitter.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+--------------------------------------------
// input    | in_valid / in_ready   | data_byte, last_byte
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data
// output   | out_valid / out_ready | piece_start, piece_length, last_piece
//
// One byte is taken every cycle while the result queue has room for two; a byte
// waits in the input register until its results are written to the result queue.
// Each byte yields zero, one or two results; the four-entry result queue drains
// one beat per cycle while out_ready is high and sets the rate for two-result bytes.
// Reset clears the configuration to whitespace mode with no split limit.
// Output stalls back up through the queue into the input register.
module delimiter_stream_splitter #(
    parameter int unsigned MAX_SEP_BYTES = 8,
    parameter int unsigned OFFSET_BITS   = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dss_pkg::BYTE_W-1:0]          data_byte,
    input  logic                                last_byte,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dss_pkg::SEP_BYTES_W-1:0]     cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dss_pkg::OUT_OFF_W-1:0]       piece_start,
    output logic [dss_pkg::OUT_OFF_W-1:0]       piece_length,
    output logic                                last_piece
);

    logic                        in_valid_reg;
    logic [dss_pkg::BYTE_W-1:0]  data_reg;
    logic                        last_reg;
    logic                        step;
    logic                        room_for_two;
    dss_pkg::push_t              push;
    dss_pkg::piece_t             head;

    // A held byte is processed once the queue can take both of its results
    assign step      = in_valid_reg && room_for_two;
    assign in_ready  = !in_valid_reg || step;
    assign cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    dss_core #(
        .MAX_SEP_BYTES (MAX_SEP_BYTES),
        .OFFSET_BITS   (OFFSET_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .data_byte (data_reg),
        .last_byte (last_reg),
        .push      (push)
    );

    dss_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room_for_two (room_for_two),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .head         (head)
    );

    assign piece_start  = head.start;
    assign piece_length = head.length;
    assign last_piece   = head.last;

endmodule

>>> hw/rtl/dss_core.sv
module dss_core #(
    parameter int unsigned MAX_SEP_BYTES = 8,
    parameter int unsigned OFFSET_BITS   = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [dss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dss_pkg::SEP_BYTES_W-1:0]     cfg_data,
    input  logic                                step,
    input  logic [dss_pkg::BYTE_W-1:0]          data_byte,
    input  logic                                last_byte,
    output dss_pkg::push_t                      push
);

    localparam int unsigned CAP_INT = (MAX_SEP_BYTES < 8) ? MAX_SEP_BYTES : 8;
    localparam logic [dss_pkg::SEP_LEN_W-1:0] SEP_CAP = dss_pkg::SEP_LEN_W'(CAP_INT);

    // Configuration registers
    logic [dss_pkg::SEP_LEN_W-1:0]   sep_len_reg;
    logic [dss_pkg::SEP_BYTES_W-1:0] sep_bytes_reg;
    logic [dss_pkg::LIMIT_W-1:0]     split_limit_reg;

    // Per-string state
    logic [OFFSET_BITS-1:0]          byte_offset_reg, byte_offset_next;
    logic [OFFSET_BITS-1:0]          piece_begin_reg, piece_begin_next;
    logic [dss_pkg::SEP_BYTES_W-1:0] match_window_reg, match_window_next;
    logic [dss_pkg::SEP_LEN_W-1:0]   skip_count_reg, skip_count_next;
    logic [dss_pkg::LIMIT_W-1:0]     splits_left_reg, splits_left_next;
    logic                            in_token_reg, in_token_next;
    logic                            remainder_mode_reg, remainder_mode_next;
    logic                            held_valid_reg, held_valid_next;
    logic [OFFSET_BITS-1:0]          held_start_reg, held_start_next;
    logic [OFFSET_BITS-1:0]          held_len_reg, held_len_next;

    logic [dss_pkg::SEP_LEN_W-1:0]   sep_n;
    logic [OFFSET_BITS-1:0]          cur_off;
    logic [OFFSET_BITS-1:0]          nxt_off;
    logic [OFFSET_BITS-1:0]          sep_n_ext;
    logic [6:0]                      bit_len;
    logic [dss_pkg::SEP_BYTES_W-1:0] tail;
    logic [dss_pkg::SEP_BYTES_W-1:0] sep_mask;
    logic                            hit;
    logic [dss_pkg::LIMIT_W-1:0]     splits_used;
    logic                            space_byte;
    logic                            limit_wr;

    function automatic logic [OFFSET_BITS-1:0] span(
        input logic [OFFSET_BITS-1:0] a,
        input logic [OFFSET_BITS-1:0] b
    );
        return (b >= a) ? (b - a) : '0;
    endfunction

    function automatic dss_pkg::piece_t mk_piece(
        input logic [OFFSET_BITS-1:0] start,
        input logic [OFFSET_BITS-1:0] len,
        input logic                   last
    );
        dss_pkg::piece_t p;
        p.start  = dss_pkg::OUT_OFF_W'(start);
        p.length = dss_pkg::OUT_OFF_W'(len);
        p.last   = last;
        return p;
    endfunction

    // Effective separator length, offsets and the shifted byte window
    assign sep_n      = (sep_len_reg > SEP_CAP) ? SEP_CAP : sep_len_reg;
    assign cur_off    = byte_offset_reg;
    assign nxt_off    = (cur_off == '1) ? cur_off : cur_off + 1'b1;
    assign sep_n_ext  = OFFSET_BITS'(sep_n);
    assign match_window_next = {data_byte, match_window_reg[dss_pkg::SEP_BYTES_W-1:8]};
    assign bit_len    = {sep_n[3:0], 3'b000};
    assign tail       = match_window_next >> (7'd64 - bit_len);
    assign sep_mask   = (sep_n >= 4'd8) ? '1 : ((64'd1 << bit_len) - 64'd1);
    assign space_byte = dss_pkg::is_space(data_byte);
    assign limit_wr   = cfg_valid && (cfg_index == dss_pkg::CFG_IDX_SPLIT_LIMIT);

    // A separator match needs no pending skip, splits left and enough bytes seen
    assign hit = (sep_n != '0) && (skip_count_reg == '0) && (splits_left_reg != '0)
                 && (nxt_off >= sep_n_ext) && (tail == (sep_bytes_reg & sep_mask));

    // One split taken, unless the limit means no limit or none is left
    assign splits_used = ((splits_left_reg != dss_pkg::LIMIT_UNBOUNDED)
                          && (splits_left_reg != '0))
                         ? splits_left_reg - 1'b1 : splits_left_reg;

    // Next state and the results of one byte
    always_comb
    begin
        logic [OFFSET_BITS-1:0] held_len_now;
        held_len_now        = span(piece_begin_reg, cur_off);
        piece_begin_next    = piece_begin_reg;
        skip_count_next     = skip_count_reg;
        splits_left_next    = splits_left_reg;
        in_token_next       = in_token_reg;
        remainder_mode_next = remainder_mode_reg;
        held_valid_next     = held_valid_reg;
        held_start_next     = held_start_reg;
        held_len_next       = held_len_reg;
        byte_offset_next    = nxt_off;
        push                = '0;

        if (sep_n != '0)
        begin
            if (skip_count_reg != '0)
            begin
                skip_count_next = skip_count_reg - 1'b1;
            end
            if (hit)
            begin
                push.valid0      = 1'b1;
                push.piece0      = mk_piece(piece_begin_reg,
                                            span(piece_begin_reg, nxt_off - sep_n_ext), 1'b0);
                piece_begin_next = nxt_off;
                skip_count_next  = sep_n - 1'b1;
                splits_left_next = splits_used;
                if (last_byte)
                begin
                    push.valid1 = 1'b1;
                    push.piece1 = mk_piece(nxt_off, '0, 1'b1);
                end
            end
            else if (last_byte)
            begin
                push.valid0 = 1'b1;
                push.piece0 = mk_piece(piece_begin_reg, span(piece_begin_reg, nxt_off), 1'b1);
            end
        end
        else if (remainder_mode_reg)
        begin
            if (last_byte)
            begin
                push.valid0 = 1'b1;
                push.piece0 = mk_piece(piece_begin_reg, span(piece_begin_reg, nxt_off), 1'b1);
            end
        end
        else if (in_token_reg)
        begin
            if (space_byte)
            begin
                held_valid_next = 1'b1;
                held_start_next = piece_begin_reg;
                held_len_next   = held_len_now;
                in_token_next   = 1'b0;
                if (last_byte)
                begin
                    push.valid0 = 1'b1;
                    push.piece0 = mk_piece(piece_begin_reg, held_len_now, 1'b1);
                end
            end
            else if (last_byte)
            begin
                push.valid0 = 1'b1;
                push.piece0 = mk_piece(piece_begin_reg, span(piece_begin_reg, nxt_off), 1'b1);
            end
        end
        else if (space_byte)
        begin
            if (last_byte && held_valid_reg)
            begin
                push.valid0 = 1'b1;
                push.piece0 = mk_piece(held_start_reg, held_len_reg, 1'b1);
            end
        end
        else
        begin
            // A new run starts here; a held run goes out first
            held_valid_next  = 1'b0;
            piece_begin_next = cur_off;
            if (splits_left_reg == '0)
            begin
                remainder_mode_next = 1'b1;
            end
            else
            begin
                in_token_next    = 1'b1;
                splits_left_next = splits_used;
            end
            if (held_valid_reg)
            begin
                push.valid0 = 1'b1;
                push.piece0 = mk_piece(held_start_reg, held_len_reg, 1'b0);
                if (last_byte)
                begin
                    push.valid1 = 1'b1;
                    push.piece1 = mk_piece(cur_off, span(cur_off, nxt_off), 1'b1);
                end
            end
            else if (last_byte)
            begin
                push.valid0 = 1'b1;
                push.piece0 = mk_piece(cur_off, span(cur_off, nxt_off), 1'b1);
            end
        end

        // The final byte clears the per-string state for the next string
        if (last_byte)
        begin
            byte_offset_next    = '0;
            piece_begin_next    = '0;
            skip_count_next     = '0;
            splits_left_next    = split_limit_reg;
            in_token_next       = 1'b0;
            remainder_mode_next = 1'b0;
            held_valid_next     = 1'b0;
            held_start_next     = '0;
            held_len_next       = '0;
        end

        if (!step)
        begin
            push = '0;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_len_reg     <= '0;
            sep_bytes_reg   <= '0;
            split_limit_reg <= dss_pkg::LIMIT_UNBOUNDED;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dss_pkg::CFG_IDX_SEP_LEN:     sep_len_reg     <= cfg_data[dss_pkg::SEP_LEN_W-1:0];
                dss_pkg::CFG_IDX_SEP_BYTES:   sep_bytes_reg   <= cfg_data;
                dss_pkg::CFG_IDX_SPLIT_LIMIT: split_limit_reg <= cfg_data[dss_pkg::LIMIT_W-1:0];
                default:                      ;
            endcase
        end
    end

    // Per-string state; a split limit write also reloads the splits left and
    // takes precedence over a byte processed in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg    <= '0;
            piece_begin_reg    <= '0;
            match_window_reg   <= '0;
            skip_count_reg     <= '0;
            splits_left_reg    <= dss_pkg::LIMIT_UNBOUNDED;
            in_token_reg       <= 1'b0;
            remainder_mode_reg <= 1'b0;
            held_valid_reg     <= 1'b0;
            held_start_reg     <= '0;
            held_len_reg       <= '0;
        end
        else if (step)
        begin
            byte_offset_reg    <= byte_offset_next;
            piece_begin_reg    <= piece_begin_next;
            match_window_reg   <= last_byte ? '0 : match_window_next;
            skip_count_reg     <= skip_count_next;
            splits_left_reg    <= limit_wr ? cfg_data[dss_pkg::LIMIT_W-1:0] : splits_left_next;
            in_token_reg       <= in_token_next;
            remainder_mode_reg <= remainder_mode_next;
            held_valid_reg     <= held_valid_next;
            held_start_reg     <= held_start_next;
            held_len_reg       <= held_len_next;
        end
        else if (limit_wr)
        begin
            splits_left_reg <= cfg_data[dss_pkg::LIMIT_W-1:0];
        end
    end

endmodule

>>> hw/rtl/dss_fifo.sv
module dss_fifo (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dss_pkg::push_t                        push,
    output logic                                  room_for_two,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output dss_pkg::piece_t                       head
);

    dss_pkg::piece_t                mem_reg [dss_pkg::FIFO_DEPTH];
    logic [dss_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dss_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dss_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic [dss_pkg::FIFO_PTR_W-1:0] wr_ptr_plus1;
    logic [dss_pkg::FIFO_CNT_W-1:0] n_push;
    logic                           pop;

    assign out_valid    = (count_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    assign room_for_two = (count_reg <= dss_pkg::FIFO_CNT_W'(dss_pkg::FIFO_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign n_push       = dss_pkg::FIFO_CNT_W'(push.valid0) + dss_pkg::FIFO_CNT_W'(push.valid1);

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + dss_pkg::FIFO_PTR_W'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + n_push - dss_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage: the first beat at the write pointer, the second after it
    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            mem_reg[wr_ptr_reg] <= push.piece0;
        end
        if (push.valid1)
        begin
            mem_reg[wr_ptr_plus1] <= push.piece1;
        end
    end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;

    localparam logic [dss_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam logic [dss_pkg::LIMIT_W-1:0]   LIMIT_NONE    = dss_pkg::LIMIT_UNBOUNDED;
    localparam int unsigned IDLE_PCT     = 8;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned QUIET_LIMIT  = 1000;
    localparam int unsigned RANDOM_ITEMS = 700;
    localparam int unsigned PHASE_ITEMS  = 45;
    localparam int unsigned MAX_REPORTS  = 50;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    logic [dss_pkg::BYTE_W-1:0]      data_byte = '0;
    logic                            last_byte = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [dss_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [dss_pkg::SEP_BYTES_W-1:0] cfg_data  = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [dss_pkg::OUT_OFF_W-1:0]   piece_start;
    logic [dss_pkg::OUT_OFF_W-1:0]   piece_length;
    logic                            last_piece;

    // Mirror of the configuration registers.
    logic [dss_pkg::SEP_LEN_W-1:0]   cur_sep_len;
    logic [dss_pkg::SEP_BYTES_W-1:0] cur_sep;
    logic [dss_pkg::LIMIT_W-1:0]     cur_limit;

    // Mirror of the per-string splitting state.
    logic [dss_pkg::OUT_OFF_W-1:0]   bytes_seen;
    logic [dss_pkg::OUT_OFF_W-1:0]   piece_from;
    logic [63:0]                     sep_window;
    logic [3:0]                      skip_left;
    logic [dss_pkg::LIMIT_W-1:0]     splits_avail;
    logic                            in_word;
    logic                            rest_mode;
    logic                            held_ok;
    logic [dss_pkg::OUT_OFF_W-1:0]   held_at;
    logic [dss_pkg::OUT_OFF_W-1:0]   held_size;

    dss_pkg::piece_t                 pieces_due[$];
    dss_pkg::piece_t                 want;
    logic [dss_pkg::BYTE_W-1:0]      str_bytes[$];
    int unsigned                     bytes_sent = 0;
    int unsigned                     idle_pct   = IDLE_PCT;
    int unsigned                     errors     = 0;
    int unsigned                     quiet      = 0;

    delimiter_stream_splitter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .piece_start  (piece_start),
        .piece_length (piece_length),
        .last_piece   (last_piece)
    );

    always #1 clk = ~clk;

    // Space, tab, newline, vertical tab, form feed and carriage return.
    function automatic logic is_blank(input logic [dss_pkg::BYTE_W-1:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    // Distance from a to b, clamped at zero.
    function automatic logic [dss_pkg::OUT_OFF_W-1:0] span(
        input logic [dss_pkg::OUT_OFF_W-1:0] a,
        input logic [dss_pkg::OUT_OFF_W-1:0] b);
        return (b >= a) ? b - a : '0;
    endfunction

    // Separator length in force, capped at the eight-byte window.
    function automatic int unsigned sep_bytes_used();
        return (cur_sep_len > 4'd8) ? 8 : int'(cur_sep_len);
    endfunction

    task automatic queue_piece(input logic [dss_pkg::OUT_OFF_W-1:0] at,
                               input logic [dss_pkg::OUT_OFF_W-1:0] len,
                               input logic fin);
        dss_pkg::piece_t p;
        p.start  = at;
        p.length = len;
        p.last   = fin;
        pieces_due = {pieces_due, p};
    endtask

    // The top limit value is never counted down.
    task automatic spend_split();
        if ((splits_avail != LIMIT_NONE) && (splits_avail != '0))
            splits_avail = splits_avail - 1'b1;
    endtask

    task automatic clear_string();
        bytes_seen   = '0;
        piece_from   = '0;
        sep_window   = '0;
        skip_left    = '0;
        splits_avail = cur_limit;
        in_word      = 1'b0;
        rest_mode    = 1'b0;
        held_ok      = 1'b0;
        held_at      = '0;
        held_size    = '0;
    endtask

    // Works out the pieces that one accepted byte releases.
    task automatic predict_pieces(input logic [dss_pkg::BYTE_W-1:0] b, input logic lst);
        logic [dss_pkg::OUT_OFF_W-1:0] cur;
        logic [dss_pkg::OUT_OFF_W-1:0] nxt;
        logic [63:0]                   mask;
        logic [63:0]                   tail;
        int unsigned                   n;
        logic                          hit;
        cur        = bytes_seen;
        nxt        = (cur == '1) ? cur : cur + 1'b1;
        n          = sep_bytes_used();
        sep_window = {b, sep_window[63:8]};
        hit        = 1'b0;
        if (n > 0) begin
            // Separator mode: bytes just after a match may not start another.
            if (skip_left != '0) begin
                skip_left = skip_left - 1'b1;
            end
            else if ((splits_avail != '0) && (nxt >= n)) begin
                mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
                tail = sep_window >> (64 - 8 * n);
                hit  = (tail == (cur_sep & mask));
            end
            if (hit) begin
                queue_piece(piece_from, span(piece_from, nxt - n), 1'b0);
                piece_from = nxt;
                skip_left  = 4'(n - 1);
                spend_split();
            end
            if (lst)
                queue_piece(piece_from, span(piece_from, nxt), 1'b1);
        end
        else if (rest_mode) begin
            if (lst)
                queue_piece(piece_from, span(piece_from, nxt), 1'b1);
        end
        else if (in_word) begin
            // A word ends; hold it until we know whether it is the final piece.
            if (is_blank(b)) begin
                held_ok   = 1'b1;
                held_at   = piece_from;
                held_size = span(piece_from, cur);
                in_word   = 1'b0;
                if (lst) begin
                    queue_piece(held_at, held_size, 1'b1);
                    held_ok = 1'b0;
                end
            end
            else if (lst) begin
                queue_piece(piece_from, span(piece_from, nxt), 1'b1);
            end
        end
        else if (is_blank(b)) begin
            if (lst && held_ok) begin
                queue_piece(held_at, held_size, 1'b1);
                held_ok = 1'b0;
            end
        end
        else begin
            // A new word starts and releases the held one.
            if (held_ok) begin
                queue_piece(held_at, held_size, 1'b0);
                held_ok = 1'b0;
            end
            piece_from = cur;
            if (splits_avail == '0) begin
                rest_mode = 1'b1;
            end
            else begin
                in_word = 1'b1;
                spend_split();
            end
            if (lst)
                queue_piece(piece_from, span(piece_from, nxt), 1'b1);
        end
        bytes_seen = nxt;
        if (lst)
            clear_string();
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        if (errors < MAX_REPORTS)
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, exp_val);
        errors++;
    endtask

    // Sends one byte beat; entered and left at a falling edge.
    task automatic push_byte(input logic [dss_pkg::BYTE_W-1:0] b, input logic lst);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        do @(posedge clk); while (!in_ready);
        predict_pieces(b, lst);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_string();
        int unsigned k;
        for (k = 0; k < str_bytes.size(); k++)
            push_byte(str_bytes[k], k == str_bytes.size() - 1);
    endtask

    // Writes one register and leaves the valid high for a following write.
    task automatic cfg_write(input logic [dss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dss_pkg::SEP_BYTES_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == dss_pkg::CFG_IDX_SEP_LEN) begin
            cur_sep_len = val[dss_pkg::SEP_LEN_W-1:0];
        end
        else if (idx == dss_pkg::CFG_IDX_SEP_BYTES) begin
            cur_sep = val;
        end
        else if (idx == dss_pkg::CFG_IDX_SPLIT_LIMIT) begin
            cur_limit    = val[dss_pkg::LIMIT_W-1:0];
            splits_avail = cur_limit;
        end
        @(negedge clk);
    endtask

    task automatic configure(input logic [63:0] len_word, input logic [63:0] sep_word,
                             input logic [63:0] lim_word);
        cfg_write(dss_pkg::CFG_IDX_SEP_LEN, len_word);
        cfg_write(dss_pkg::CFG_IDX_SEP_BYTES, sep_word);
        cfg_write(dss_pkg::CFG_IDX_SPLIT_LIMIT, lim_word);
        cfg_valid <= 1'b0;
    endtask

    // Drops the input valid and waits until every piece has come out.
    task automatic settle();
        in_valid <= 1'b0;
        while (pieces_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [dss_pkg::BYTE_W-1:0] pick_sep_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h2C;
            1:       return 8'h3B;
            2:       return 8'h00;
            3:       return 8'hFF;
            4:       return 8'h61;
            default: return dss_pkg::BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Separator bytes, letters and whitespace in equal shares, now and then a random byte.
    function automatic logic [dss_pkg::BYTE_W-1:0] pick_byte(input int unsigned n);
        int unsigned s;
        case ($urandom_range(0, 9))
            0, 1, 2: return (n > 0) ? cur_sep[8 * $urandom_range(0, n - 1) +: 8] : 8'h61;
            3, 4, 5: return 8'h61 + dss_pkg::BYTE_W'($urandom_range(0, 2));
            6, 7, 8:
            begin
                s = $urandom_range(0, 5);
                return (s == 0) ? 8'h20 : 8'h08 + dss_pkg::BYTE_W'(s);
            end
            default: return dss_pkg::BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Fills the string buffer: whole separators with random content between,
    // now and then a long string or plain noise.
    task automatic build_string();
        int unsigned n;
        int unsigned kind;
        int unsigned target;
        int unsigned k;
        n    = sep_bytes_used();
        kind = $urandom_range(0, 19);
        str_bytes.delete();
        target = (kind == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
        while (str_bytes.size() < target) begin
            if (kind < 3 && kind != 0) begin
                str_bytes = {str_bytes, dss_pkg::BYTE_W'($urandom_range(0, 255))};
            end
            else if ((n > 0) && ($urandom_range(0, 3) == 0)) begin
                for (k = 0; k < n; k++)
                    str_bytes = {str_bytes, cur_sep[8 * k +: 8]};
            end
            else begin
                str_bytes = {str_bytes, pick_byte(n)};
            end
        end
    endtask

    // Whitespace mode: leading blanks, a held word, blank bounds and an all-blank string.
    task automatic test_whitespace();
        configure('0, '0, 64'(LIMIT_NONE));
        str_bytes = '{8'h20, 8'h61, 8'h09, 8'hFF, 8'h0B};
        send_string();
        str_bytes = '{8'h0A, 8'h0D};
        send_string();
        settle();
    endtask

    // Whitespace mode with a split limit, then a limit of zero written alone.
    task automatic test_split_limit();
        configure('0, '0, 64'd1);
        str_bytes = '{8'h61, 8'h20, 8'h62, 8'h20};
        send_string();
        settle();
        cfg_write(dss_pkg::CFG_IDX_SPLIT_LIMIT, 64'd0);
        cfg_valid <= 1'b0;
        str_bytes = '{8'h78};
        send_string();
        settle();
    endtask

    // Overlapping separators and an empty remainder after a final match.
    task automatic test_separator();
        configure(64'd2, 64'h2C2C, 64'(LIMIT_NONE));
        str_bytes = '{8'h2C, 8'h2C, 8'h2C};
        send_string();
        str_bytes = '{8'h61, 8'h2C, 8'h2C};
        send_string();
        settle();
    endtask

    // A length above eight acts as eight.
    task automatic test_long_separator();
        configure('1, 64'h4847_4645_4443_4241, 64'(LIMIT_NONE));
        str_bytes = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48};
        send_string();
        settle();
    endtask

    // Switch from whitespace to separator mode within a string; the held word is lost.
    task automatic test_config_mid_string();
        configure('0, '0, 64'(LIMIT_NONE));
        push_byte(8'h61, 1'b0);
        push_byte(8'h20, 1'b0);
        settle();
        configure(64'd1, 64'h2C, 64'd0);
        str_bytes = '{8'h78, 8'h2C, 8'h79};
        send_string();
        settle();
    endtask

    // Random strings over a series of settings, extremes first.
    task automatic test_random_strings();
        int unsigned phase;
        int unsigned stop_at;
        int unsigned phase_end;
        int unsigned k;
        logic [63:0] len_word;
        logic [63:0] sep_word;
        logic [63:0] lim_word;
        stop_at = bytes_sent + RANDOM_ITEMS;
        phase   = 0;
        while (bytes_sent < stop_at) begin
            settle();
            for (k = 0; k < 8; k++)
                sep_word[8 * k +: 8] = pick_sep_byte();
            len_word = {$urandom, $urandom};
            lim_word = {$urandom, $urandom};
            idle_pct = IDLE_PCT;
            case (phase)
                0:
                begin
                    len_word[3:0]  = 4'd0;
                    sep_word       = '1;
                    lim_word[30:0] = LIMIT_NONE;
                end
                1:
                begin
                    len_word[3:0]  = 4'd8;
                    lim_word[30:0] = LIMIT_NONE;
                end
                2:
                begin
                    len_word[3:0]  = 4'd15;
                    sep_word       = '0;
                    lim_word[30:0] = LIMIT_NONE;
                end
                3:
                begin
                    // A long stretch with no idling on either side.
                    len_word[3:0]  = 4'd1;
                    lim_word[30:0] = '0;
                    idle_pct       = 0;
                end
                4:
                begin
                    len_word[3:0]  = 4'd0;
                    lim_word[30:0] = 31'($urandom_range(1, 3));
                end
                default:
                begin
                    case ($urandom_range(0, 5))
                        0:       len_word[3:0] = 4'd0;
                        1, 2, 3: len_word[3:0] = 4'($urandom_range(1, 3));
                        4:       len_word[3:0] = 4'($urandom_range(4, 8));
                        default: len_word[3:0] = 4'($urandom_range(9, 15));
                    endcase
                    case ($urandom_range(0, 3))
                        0:       lim_word[30:0] = LIMIT_NONE;
                        1:       lim_word[30:0] = 31'($urandom_range(0, 3));
                        2:       lim_word[30:0] = 31'($urandom_range(0, 32'h7FFF_FFFE));
                        default: lim_word[30:0] = LIMIT_NONE - 1'b1;
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        cfg_write(CFG_IDX_SPARE, {$urandom, $urandom});
                end
            endcase
            configure(len_word, sep_word, lim_word);
            phase_end = bytes_sent + ((phase == 3) ? 3 * PHASE_ITEMS : PHASE_ITEMS);
            while (bytes_sent < phase_end) begin
                build_string();
                send_string();
            end
            phase++;
        end
        idle_pct = IDLE_PCT;
    endtask

    // Random back-pressure on the result side.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= idle_pct);

    // Each result beat is checked against the oldest predicted piece.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pieces_due.size() == 0) begin
                note_mismatch("piece with none predicted, start", piece_start, '0);
            end
            else begin
                want = pieces_due.pop_front();
                if (piece_start !== want.start)
                    note_mismatch("piece_start", piece_start, want.start);
                if (piece_length !== want.length)
                    note_mismatch("piece_length", piece_length, want.length);
                if (last_piece !== want.last)
                    note_mismatch("last_piece", 32'(last_piece), 32'(want.last));
            end
        end
    end

    // Ends the run when no beat moves on any channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end
        else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        cur_sep_len = '0;
        cur_sep     = '0;
        cur_limit   = LIMIT_NONE;
        clear_string();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_whitespace();
        test_split_limit();
        test_separator();
        test_long_separator();
        test_config_mid_string();
        test_random_strings();
        settle();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/dss_pkg.sv
hw/rtl/dss_core.sv
hw/rtl/dss_fifo.sv
hw/rtl/delimiter_stream_splitter.sv
tb/sv/tb_top.sv
